### hdl/smt_pkg.sv
package smt_pkg;

   localparam int NumTimers = 16;
   localparam int MsPerTick = 55;
   localparam int MaxFired  = 16;

   localparam int IdW   = 4;
   localparam int TimeW = 32;
   localparam int MsW   = 31;
   localparam int PosW  = $clog2(NumTimers) + 1;
   localparam int ProdW = TimeW + $clog2(MsPerTick + 1);
   localparam int RecW  = 2 * TimeW;

   // reciprocal of the tick length, exact for every rounded-up interval
   localparam int RecipShift = TimeW + $clog2(MsPerTick) - 1;
   localparam logic [TimeW-1:0] RecipMul =
      TimeW'(((64'd1 << RecipShift) + 64'(MsPerTick) - 64'd1) / 64'(MsPerTick));

   localparam logic [MsW-1:0] MsMax = '1;

   typedef enum logic [2:0] {
      FN_TICK  = 3'd0,
      FN_SET   = 3'd1,
      FN_START = 3'd2,
      FN_STOP  = 3'd3,
      FN_READ  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      KIND_EXPIRY = 2'd0,
      KIND_READ   = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [2:0]     func;
      logic [IdW-1:0] timer_id;
      logic [MsW-1:0] interval_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]     kind;
      logic [IdW-1:0] timer_id_res;
      logic [MsW-1:0] remaining_ms;
      logic           last;
   } rsp_type;

   // signed difference a - b is not negative
   function automatic logic not_before(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
      logic [TimeW-1:0] d;
      d = a - b;
      return !d[TimeW-1];
   endfunction

endpackage

### hdl/smt_ram.sv
module smt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sorted_multi_timer_core.sv
// channel  direction  ports                               beat
// req      in         req_valid, req_stall, req_data      func, timer_id, interval_ms
// rsp      out        rsp_valid, rsp_stall, rsp_data      kind, timer_id_res, remaining_ms, last
//
// one request at a time; the list walk runs on the order memory and the timer record
// memory, each with a registered read. set divides by reciprocal multiply, then reads and
// writes the record; read reads the record and multiplies; stop scans the list and shifts
// later entries up; start does the same, then compares entries and moves entries down; tick
// checks heads, sends an expiry beat per expired timer and shifts entries up the list.
// synchronous reset clears the tick count, the list length, the running and duration bits.
// a stalled rsp beat holds in the output register; req is taken only once the sequencer is idle.
module sorted_multi_timer_core import smt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [23:0] {
      S_IDLE  = 24'h000001,
      S_DIV   = 24'h000002,
      S_SETRD = 24'h000004,
      S_SETWR = 24'h000008,
      S_TRD   = 24'h000010,
      S_TOA   = 24'h000020,
      S_TCMP  = 24'h000040,
      S_ERD   = 24'h000080,
      S_EOUT  = 24'h000100,
      S_SHRD  = 24'h000200,
      S_SHWR  = 24'h000400,
      S_RMRD  = 24'h000800,
      S_RMCHK = 24'h001000,
      S_STRD  = 24'h002000,
      S_STWR  = 24'h004000,
      S_IRD   = 24'h008000,
      S_IOA   = 24'h010000,
      S_ICMP  = 24'h020000,
      S_IRRD  = 24'h040000,
      S_IRWR  = 24'h080000,
      S_IPUT  = 24'h100000,
      S_RDRD  = 24'h200000,
      S_RDMUL = 24'h400000,
      S_DONE  = 24'h800000
   } state_type;

   state_type            state_ff, state_in;
   logic [TimeW-1:0]     tick_ff, tick_in;
   logic [PosW-1:0]      len_ff, len_in;
   logic [NumTimers-1:0] running_ff, running_in;
   logic [NumTimers-1:0] durv_ff, durv_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [2:0]           func_ff, func_in;
   logic [IdW-1:0]       id_ff, id_in;
   logic                 zero_ff, zero_in;
   logic [TimeW-1:0]     wk_ff, wk_in;
   logic [PosW-1:0]      p_ff, p_in;
   logic [PosW-1:0]      n_ff, n_in;
   logic [PosW-1:0]      k_ff, k_in;
   logic [PosW-1:0]      q_ff, q_in;
   logic [PosW-1:0]      sh_ff, sh_in;
   logic [ProdW-1:0]     prod_ff, prod_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 ord_we, ord_re;
   logic [IdW-1:0]       ord_waddr, ord_raddr, ord_wdata, ord_rdata;
   logic                 rec_we, rec_re;
   logic [IdW-1:0]       rec_waddr, rec_raddr;
   logic [RecW-1:0]      rec_wdata, rec_rdata;

   logic                 out_free;
   logic [RecW-1:0]      recip_prod;
   logic [TimeW-1:0]     dur;
   logic [TimeW-1:0]     diff;
   logic [PosW-1:0]      erd_pos;
   logic [PosW:0]        shsum;
   state_type            cont_state;

   smt_ram #(.Width(IdW), .Depth(NumTimers)) u_order (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_en   (ord_re),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   smt_ram #(.Width(RecW), .Depth(NumTimers)) u_record (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_en   (rec_re),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      len_in       = len_ff;
      running_in   = running_ff;
      durv_in      = durv_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      zero_in      = zero_ff;
      wk_in        = wk_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      sh_in        = sh_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      ord_we    = 1'b0;
      ord_waddr = '0;
      ord_wdata = '0;
      ord_re    = 1'b0;
      ord_raddr = '0;
      rec_we    = 1'b0;
      rec_waddr = id_ff;
      rec_wdata = '0;
      rec_re    = 1'b0;
      rec_raddr = id_ff;

      recip_prod = RecW'(wk_ff) * RecW'(RecipMul);
      dur     = durv_ff[id_ff] ? rec_rdata[RecW-1:TimeW] : '0;
      diff    = rec_rdata[TimeW-1:0] - tick_ff;
      erd_pos = n_ff - k_ff - PosW'(1);
      shsum   = {1'b0, q_ff} + {1'b0, sh_ff};

      case (func_ff)
         FN_TICK:  cont_state = S_IDLE;
         FN_START: cont_state = S_STRD;
         default:  cont_state = S_DONE;
      endcase

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_data.func;
               id_in   = req_data.timer_id;
               case (req_data.func)
                  FN_TICK: begin
                     tick_in  = tick_ff + TimeW'(1);
                     n_in     = '0;
                     state_in = S_TRD;
                  end
                  FN_SET: begin
                     wk_in    = {1'b0, req_data.interval_ms} + TimeW'(MsPerTick - 1);
                     zero_in  = (req_data.interval_ms == '0);
                     state_in = S_DIV;
                  end
                  FN_START, FN_STOP: begin
                     if (running_ff[req_data.timer_id]) begin
                        running_in[req_data.timer_id] = 1'b0;
                        p_in     = '0;
                        state_in = S_RMRD;
                     end else if (req_data.func == FN_START) begin
                        state_in = S_STRD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  FN_READ: state_in = S_RDRD;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DIV: begin
            // quotient by reciprocal multiply
            wk_in    = TimeW'(recip_prod >> RecipShift);
            state_in = S_SETRD;
         end
         S_SETRD: begin
            rec_re   = 1'b1;
            state_in = S_SETWR;
         end
         S_SETWR: begin
            rec_we    = 1'b1;
            rec_wdata = {(zero_ff ? TimeW'(0) : wk_ff + TimeW'(1)), rec_rdata[TimeW-1:0]};
            durv_in[id_ff] = 1'b1;
            state_in  = S_DONE;
         end
         S_TRD: begin
            if (n_ff < len_ff && n_ff < PosW'(MaxFired)) begin
               ord_re    = 1'b1;
               ord_raddr = n_ff[IdW-1:0];
               state_in  = S_TOA;
            end else if (n_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               k_in     = '0;
               state_in = S_ERD;
            end
         end
         S_TOA: begin
            rec_re    = 1'b1;
            rec_raddr = ord_rdata;
            state_in  = S_TCMP;
         end
         S_TCMP: begin
            if (not_before(tick_ff, rec_rdata[TimeW-1:0])) begin
               n_in     = n_ff + PosW'(1);
               state_in = S_TRD;
            end else if (n_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               k_in     = '0;
               state_in = S_ERD;
            end
         end
         S_ERD: begin
            ord_re    = 1'b1;
            ord_raddr = erd_pos[IdW-1:0];
            state_in  = S_EOUT;
         end
         S_EOUT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.kind         = KIND_EXPIRY;
               rsp_in.timer_id_res = ord_rdata;
               rsp_in.remaining_ms = '0;
               rsp_in.last         = (k_ff == n_ff - PosW'(1));
               running_in[ord_rdata] = 1'b0;
               if (k_ff == n_ff - PosW'(1)) begin
                  q_in     = '0;
                  sh_in    = n_ff;
                  state_in = S_SHRD;
               end else begin
                  k_in     = k_ff + PosW'(1);
                  state_in = S_ERD;
               end
            end
         end
         S_SHRD: begin
            if (shsum < {1'b0, len_ff}) begin
               ord_re    = 1'b1;
               ord_raddr = shsum[IdW-1:0];
               state_in  = S_SHWR;
            end else begin
               len_in   = len_ff - sh_ff;
               state_in = cont_state;
            end
         end
         S_SHWR: begin
            ord_we    = 1'b1;
            ord_waddr = q_ff[IdW-1:0];
            ord_wdata = ord_rdata;
            q_in      = q_ff + PosW'(1);
            state_in  = S_SHRD;
         end
         S_RMRD: begin
            if (p_ff < len_ff) begin
               ord_re    = 1'b1;
               ord_raddr = p_ff[IdW-1:0];
               state_in  = S_RMCHK;
            end else begin
               state_in = cont_state;
            end
         end
         S_RMCHK: begin
            if (ord_rdata == id_ff) begin
               q_in     = p_ff;
               sh_in    = PosW'(1);
               state_in = S_SHRD;
            end else begin
               p_in     = p_ff + PosW'(1);
               state_in = S_RMRD;
            end
         end
         S_STRD: begin
            rec_re   = 1'b1;
            state_in = S_STWR;
         end
         S_STWR: begin
            if (dur == '0) begin
               state_in = S_DONE;
            end else begin
               rec_we    = 1'b1;
               rec_wdata = {dur, tick_ff + dur};
               wk_in     = tick_ff + dur;
               running_in[id_ff] = 1'b1;
               p_in      = '0;
               state_in  = S_IRD;
            end
         end
         S_IRD: begin
            if (p_ff < len_ff) begin
               ord_re    = 1'b1;
               ord_raddr = p_ff[IdW-1:0];
               state_in  = S_IOA;
            end else if (len_ff >= PosW'(NumTimers)) begin
               state_in = S_DONE;
            end else begin
               q_in     = len_ff;
               state_in = S_IRRD;
            end
         end
         S_IOA: begin
            rec_re    = 1'b1;
            rec_raddr = ord_rdata;
            state_in  = S_ICMP;
         end
         S_ICMP: begin
            if (not_before(rec_rdata[TimeW-1:0], wk_ff)) begin
               if (len_ff >= PosW'(NumTimers)) begin
                  state_in = S_DONE;
               end else begin
                  q_in     = len_ff;
                  state_in = S_IRRD;
               end
            end else begin
               p_in     = p_ff + PosW'(1);
               state_in = S_IRD;
            end
         end
         S_IRRD: begin
            if (q_ff > p_ff) begin
               ord_re    = 1'b1;
               ord_raddr = IdW'(q_ff - PosW'(1));
               state_in  = S_IRWR;
            end else begin
               state_in = S_IPUT;
            end
         end
         S_IRWR: begin
            ord_we    = 1'b1;
            ord_waddr = q_ff[IdW-1:0];
            ord_wdata = ord_rdata;
            q_in      = q_ff - PosW'(1);
            state_in  = S_IRRD;
         end
         S_IPUT: begin
            ord_we    = 1'b1;
            ord_waddr = p_ff[IdW-1:0];
            ord_wdata = id_ff;
            len_in    = len_ff + PosW'(1);
            state_in  = S_DONE;
         end
         S_RDRD: begin
            rec_re   = 1'b1;
            state_in = S_RDMUL;
         end
         S_RDMUL: begin
            if (running_ff[id_ff] && diff != '0 && !diff[TimeW-1]) begin
               prod_in = ProdW'(diff) * ProdW'(MsPerTick);
            end else begin
               prod_in = '0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.timer_id_res = id_ff;
               rsp_in.last         = 1'b1;
               if (func_ff == FN_READ) begin
                  rsp_in.kind         = KIND_READ;
                  rsp_in.remaining_ms = (prod_ff > ProdW'(MsMax)) ? MsMax
                                                                  : prod_ff[MsW-1:0];
               end else begin
                  rsp_in.kind         = KIND_DONE;
                  rsp_in.remaining_ms = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         len_ff       <= '0;
         running_ff   <= '0;
         durv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         len_ff       <= len_in;
         running_ff   <= running_in;
         durv_ff      <= durv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      id_ff   <= id_in;
      zero_ff <= zero_in;
      wk_ff   <= wk_in;
      p_ff    <= p_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
      q_ff    <= q_in;
      sh_ff   <= sh_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= PosW'(NumTimers))
      else $error("list length beyond bank size");

   a_list_matches_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> $countones(running_ff) == int'(len_ff))
      else $error("running timers disagree with list length");

endmodule
